/* rtl/core/prp_duplicate_discard_core_assert.svh */
// Assertion macros shared by the PRP duplicate discard RTL.
`ifndef PRP_DUPLICATE_DISCARD_CORE_ASSERT_SVH
`define PRP_DUPLICATE_DISCARD_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PRP_DD_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("prp_dd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PRP_DD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("prp_dd assertion failed");

// Next-cycle implication that is also checked during reset.
`define PRP_DD_ASSERT_ALWAYS(label, clock, ante, cons) \
  label: assert property (@(posedge clock) (ante) |=> (cons)) \
    else $error("prp_dd assertion failed");

`endif

/* rtl/core/prp_dd_pkg.sv */
// Package with types, constants and defaults of the PRP duplicate discard core.
`timescale 1ns / 1ps
`default_nettype none
package prp_dd_pkg;

  localparam int DEVICE_COUNT_DEFAULT    = 128;
  localparam int SLOT_INDEX_BITS_DEFAULT = 12;

  localparam logic [15:0] PRP_ETHERTYPE    = 16'h88BA;
  localparam logic [15:0] PRP_SUFFIX       = {8'h88, 8'hFB};
  localparam logic [16:0] ETH_HEADER_BYTES = 17'd14;
  localparam logic [16:0] MAX_FRAME_BYTES  = 17'h0FFFF;
  localparam logic [31:0] LIMIT_RESET      = 32'd20000000;

  localparam int          CFG_ADDR_BITS        = 3;
  localparam logic [0:0]  REG_INACTIVITY_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    VERDICT_DROP  = 2'd0,
    VERDICT_PASS  = 2'd1,
    VERDICT_STRIP = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_LENGTH    = 3'd1,
    CAUSE_SUFFIX    = 3'd2,
    CAUSE_DEVICE    = 3'd3,
    CAUSE_DUPLICATE = 3'd4
  } cause_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_CLEAR,
    S_COMMIT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/prp_dd_desc_if.sv */
// Channel interface for frame descriptor words.
`timescale 1ns / 1ps
`default_nettype none
interface prp_dd_desc_if;
  logic        valid;
  logic        ready;
  logic [16:0] frame_length;
  logic [15:0] ether_type;
  logic [7:0]  dest_low_byte;
  logic [15:0] seq_number;
  logic [15:0] trailer_suffix;
  logic [63:0] arrival_time_ns;

  modport source (
    output valid, frame_length, ether_type, dest_low_byte, seq_number,
           trailer_suffix, arrival_time_ns,
    input  ready
  );

  modport sink (
    input  valid, frame_length, ether_type, dest_low_byte, seq_number,
           trailer_suffix, arrival_time_ns,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/core/prp_dd_result_if.sv */
// Channel interface for verdict words.
`timescale 1ns / 1ps
`default_nettype none
interface prp_dd_result_if;
  import prp_dd_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  cause_t   drop_cause;

  modport source (
    output valid, verdict, drop_cause,
    input  ready
  );

  modport sink (
    input  valid, verdict, drop_cause,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/core/prp_duplicate_discard_core.sv */
// PRP duplicate discard core: a sequencer over three RAMs judges one descriptor word at a time.
// Header-decided frames go from idle straight to the hand-off state; PRP frames first pass the slot
// read and decide states, plus a clear state over the device's mark rows and a commit state when
// its marks are cleared. The hand-off waits until the result register is free; a new word is taken
// only in idle. Reset: the mark and last-time RAMs are swept clear one mark row per cycle, 16384 rows
// at the default sizes; no word is accepted until then.
`timescale 1ns / 1ps
`default_nettype none
`include "prp_duplicate_discard_core_assert.svh"
module prp_duplicate_discard_core #(
  parameter int DEVICE_COUNT    = prp_dd_pkg::DEVICE_COUNT_DEFAULT,
  parameter int SLOT_INDEX_BITS = prp_dd_pkg::SLOT_INDEX_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [prp_dd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready,
  prp_dd_desc_if.sink                               desc,
  prp_dd_result_if.source                           result
);
  import prp_dd_pkg::*;

  localparam int DEV_BITS       = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int EPOCH_BITS     = 16 - SLOT_INDEX_BITS;
  localparam int LANE_BITS      = (SLOT_INDEX_BITS > 5) ? 5 : SLOT_INDEX_BITS - 1;
  localparam int LANES          = 1 << LANE_BITS;
  localparam int ROW_BITS       = SLOT_INDEX_BITS - LANE_BITS;
  localparam int SLOT_DEPTH     = DEVICE_COUNT << SLOT_INDEX_BITS;
  localparam int ROW_DEPTH      = DEVICE_COUNT << ROW_BITS;
  localparam int SLOT_ADDR_BITS = DEV_BITS + SLOT_INDEX_BITS;
  localparam int ROW_ADDR_BITS  = DEV_BITS + ROW_BITS;

  logic [31:0] inactivity_limit_ns;

  state_t state, state_next;

  logic [DEV_BITS-1:0]        dev;
  logic [SLOT_INDEX_BITS-1:0] slot;
  logic [EPOCH_BITS-1:0]      epoch;
  logic [63:0]                now;
  logic                       in_load;

  verdict_t res_verdict, res_verdict_next;
  cause_t   res_cause, res_cause_next;

  logic [ROW_ADDR_BITS-1:0] sweep, sweep_next;
  logic                     sweep_last;

  logic     out_valid, out_load;
  verdict_t out_verdict;
  cause_t   out_cause;

  logic                      time_we, epoch_we, mark_we;
  logic [DEV_BITS-1:0]       time_addr;
  logic [SLOT_ADDR_BITS-1:0] epoch_addr;
  logic [ROW_ADDR_BITS-1:0]  mark_addr;
  logic [63:0]               time_wdata, time_rdata;
  logic [EPOCH_BITS-1:0]     epoch_rdata;
  logic [LANES-1:0]          mark_wdata, mark_rdata, lane_bit;

  logic [64:0] diff;
  logic        newer, clear_marks, marked, dup, dev_ok;

  prp_dd_cfg u_cfg (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .inactivity_limit_ns (inactivity_limit_ns)
  );

  prp_dd_ram #(.WIDTH(64), .DEPTH(DEVICE_COUNT), .ADDR_BITS(DEV_BITS)) u_time_ram (
    .clk (clk), .we (time_we), .addr (time_addr), .wdata (time_wdata), .rdata (time_rdata)
  );

  prp_dd_ram #(.WIDTH(EPOCH_BITS), .DEPTH(SLOT_DEPTH), .ADDR_BITS(SLOT_ADDR_BITS)) u_epoch_ram (
    .clk (clk), .we (epoch_we), .addr (epoch_addr), .wdata (epoch), .rdata (epoch_rdata)
  );

  prp_dd_ram #(.WIDTH(LANES), .DEPTH(ROW_DEPTH), .ADDR_BITS(ROW_ADDR_BITS)) u_mark_ram (
    .clk (clk), .we (mark_we), .addr (mark_addr), .wdata (mark_wdata), .rdata (mark_rdata)
  );

  assign desc.ready        = (state == S_IDLE);
  assign in_load           = desc.valid && (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.verdict    = out_verdict;
  assign result.drop_cause = out_cause;

  assign dev_ok     = ({1'b0, desc.dest_low_byte} < 9'(DEVICE_COUNT));
  assign lane_bit   = {{(LANES-1){1'b0}}, 1'b1} << slot[LANE_BITS-1:0];
  assign diff       = {1'b0, now} - {1'b0, time_rdata};
  assign newer      = !diff[64] && (diff[63:0] != 64'd0);
  assign clear_marks = newer && (diff[63:0] > {32'd0, inactivity_limit_ns});
  assign marked     = (mark_rdata & lane_bit) != '0;
  assign dup        = marked && (epoch_rdata == epoch);
  assign sweep_last = (state == S_INIT) ? (sweep == ROW_ADDR_BITS'(ROW_DEPTH - 1))
                                        : (sweep[ROW_BITS-1:0] == {ROW_BITS{1'b1}});

  always_comb begin
    state_next       = state;
    res_verdict_next = res_verdict;
    res_cause_next   = res_cause;
    sweep_next       = sweep;
    out_load         = 1'b0;
    time_we          = 1'b0;
    time_addr        = dev;
    time_wdata       = now;
    epoch_we         = 1'b0;
    epoch_addr       = {dev, slot};
    mark_we          = 1'b0;
    mark_addr        = {dev, slot[SLOT_INDEX_BITS-1:LANE_BITS]};
    mark_wdata       = '0;
    unique case (state)
      S_INIT: begin
        mark_we    = 1'b1;
        mark_addr  = sweep;
        time_addr  = sweep[ROW_ADDR_BITS-1 -: DEV_BITS];
        time_we    = (sweep[ROW_BITS-1:0] == '0);
        time_wdata = 64'd0;
        sweep_next = sweep + 1'b1;
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (desc.valid) begin
          state_next       = S_DONE;
          res_verdict_next = VERDICT_DROP;
          res_cause_next   = CAUSE_NONE;
          priority if (desc.frame_length < ETH_HEADER_BYTES) begin
            res_cause_next = CAUSE_LENGTH;
          end else if (desc.ether_type != PRP_ETHERTYPE) begin
            res_verdict_next = VERDICT_PASS;
          end else if (desc.frame_length > MAX_FRAME_BYTES) begin
            res_cause_next = CAUSE_LENGTH;
          end else if (desc.trailer_suffix != PRP_SUFFIX) begin
            res_cause_next = CAUSE_SUFFIX;
          end else if (!dev_ok) begin
            res_cause_next = CAUSE_DEVICE;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        time_we  = newer;
        epoch_we = 1'b1;
        if (clear_marks) begin
          sweep_next = '0;
          state_next = S_CLEAR;
        end else begin
          state_next = S_DONE;
          if (dup) begin
            res_verdict_next = VERDICT_DROP;
            res_cause_next   = CAUSE_DUPLICATE;
          end else begin
            mark_we          = 1'b1;
            mark_wdata       = mark_rdata | lane_bit;
            res_verdict_next = VERDICT_STRIP;
            res_cause_next   = CAUSE_NONE;
          end
        end
      end
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_addr  = {dev, sweep[ROW_BITS-1:0]};
        sweep_next = sweep + 1'b1;
        if (sweep_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        mark_we          = 1'b1;
        mark_wdata       = lane_bit;
        res_verdict_next = VERDICT_STRIP;
        res_cause_next   = CAUSE_NONE;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_verdict <= res_verdict_next;
    res_cause   <= res_cause_next;
    if (in_load) begin
      dev   <= desc.dest_low_byte[DEV_BITS-1:0];
      slot  <= desc.seq_number[SLOT_INDEX_BITS-1:0];
      epoch <= desc.seq_number[15:SLOT_INDEX_BITS];
      now   <= desc.arrival_time_ns;
    end
    if (out_load) begin
      out_verdict <= res_verdict;
      out_cause   <= res_cause;
    end
  end

  `PRP_DD_ASSERT_IMPL(a_verdict_cause, clk, rst, out_valid, (out_verdict == VERDICT_DROP) == (out_cause != CAUSE_NONE))
  `PRP_DD_ASSERT_ALWAYS(a_init_after_reset, clk, rst, state == S_INIT)
  `PRP_DD_ASSERT_IMPL(a_no_mark_write_idle, clk, rst, state == S_IDLE || state == S_LOOKUP || state == S_DONE, !mark_we)
  `PRP_DD_ASSERT_NEXT(a_clear_to_commit, clk, rst, state == S_CLEAR && sweep_last, state == S_COMMIT)

endmodule
`default_nettype wire

/* rtl/core/prp_dd_ram.sv */
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module prp_dd_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [WIDTH-1:0]     wdata,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/core/prp_dd_cfg.sv */
// APB register block holding the inactivity limit.
`timescale 1ns / 1ps
`default_nettype none
module prp_dd_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [prp_dd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output logic      [31:0]                        inactivity_limit_ns
);
  import prp_dd_pkg::*;

  logic [0:0] reg_index;
  logic       wr_limit;

  assign reg_index = paddr[CFG_ADDR_BITS-1:2];
  assign pready    = 1'b1;
  assign wr_limit  = psel && penable && pwrite && (reg_index == REG_INACTIVITY_LIMIT);
  assign prdata    = (reg_index == REG_INACTIVITY_LIMIT) ? inactivity_limit_ns : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inactivity_limit_ns <= LIMIT_RESET;
    end else if (wr_limit) begin
      inactivity_limit_ns <= pwdata;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_prp_duplicate_discard_core.sv */
// Self-checking testbench for the PRP duplicate discard core, checking each verdict word.
`timescale 1ns / 1ps
module tb_prp_duplicate_discard_core;
  import prp_dd_pkg::*;

  localparam int DEVICES     = DEVICE_COUNT_DEFAULT;
  localparam int SLOT_BITS   = SLOT_INDEX_BITS_DEFAULT;
  localparam int SLOTS       = 1 << SLOT_BITS;
  localparam int EPOCH_BITS  = 16 - SLOT_BITS;
  localparam int HOT_DEVICES = 8;
  localparam int HISTORY     = 16;
  localparam int STALL_LIMIT = 60000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 450;

  localparam logic [CFG_ADDR_BITS-1:0] LIMIT_ADDR = CFG_ADDR_BITS'(REG_INACTIVITY_LIMIT) << 2;
  localparam logic [CFG_ADDR_BITS-1:0] SPARE_ADDR = LIMIT_ADDR + CFG_ADDR_BITS'(4);

  typedef struct {
    bit [16:0] len;
    bit [15:0] etype;
    bit [7:0]  dev;
    bit [15:0] seq;
    bit [15:0] suffix;
    bit [63:0] stamp;
  } frame_desc_t;

  typedef struct {
    verdict_t verdict;
    cause_t   cause;
  } verdict_word_t;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  prp_dd_desc_if   desc_ch ();
  prp_dd_result_if result_ch ();

  prp_duplicate_discard_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .desc    (desc_ch),
    .result  (result_ch)
  );

  frame_desc_t   pend_q [$];
  frame_desc_t   hist_q [$];
  verdict_word_t verdict_q [$];
  frame_desc_t   on_bus;
  verdict_word_t want;

  bit [31:0]           limit_ns;
  bit [SLOTS-1:0]      seen_mark [DEVICES];
  bit [EPOCH_BITS-1:0] slot_epoch [DEVICES][SLOTS];
  bit [63:0]           dev_stamp [DEVICES];

  bit [63:0] gen_last [DEVICES];
  bit [15:0] next_seq [DEVICES];
  bit [63:0] t_now;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic verdict_word_t judge_frame(frame_desc_t f);
    verdict_word_t       w;
    bit [SLOT_BITS-1:0]  slot;
    bit [EPOCH_BITS-1:0] ep;
    bit                  hit;
    w.verdict = VERDICT_DROP;
    w.cause   = CAUSE_NONE;
    if (f.len < ETH_HEADER_BYTES) begin
      w.cause = CAUSE_LENGTH;
    end else if (f.etype != PRP_ETHERTYPE) begin
      w.verdict = VERDICT_PASS;
    end else if (f.len > MAX_FRAME_BYTES) begin
      w.cause = CAUSE_LENGTH;
    end else if (f.suffix != PRP_SUFFIX) begin
      w.cause = CAUSE_SUFFIX;
    end else if (f.dev >= DEVICES) begin
      w.cause = CAUSE_DEVICE;
    end else begin
      if (f.stamp > dev_stamp[f.dev]) begin
        if (f.stamp - dev_stamp[f.dev] > 64'(limit_ns)) seen_mark[f.dev] = '0;
        dev_stamp[f.dev] = f.stamp;
      end
      slot = f.seq[SLOT_BITS-1:0];
      ep   = f.seq[15:SLOT_BITS];
      hit  = seen_mark[f.dev][slot] && slot_epoch[f.dev][slot] == ep;
      slot_epoch[f.dev][slot] = ep;
      if (hit) begin
        w.cause = CAUSE_DUPLICATE;
      end else begin
        seen_mark[f.dev][slot] = 1'b1;
        w.verdict = VERDICT_STRIP;
      end
    end
    return w;
  endfunction

  function automatic void flag_mismatch(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  task automatic config_write(input logic [CFG_ADDR_BITS-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) limit_ns = data;
  endtask

  task automatic add_frame(input bit [16:0] len, input bit [15:0] etype, input bit [7:0] dev,
                           input bit [15:0] seq, input bit [15:0] suffix,
                           input bit [63:0] stamp);
    frame_desc_t f;
    f = '{len, etype, dev, seq, suffix, stamp};
    pend_q.push_back(f);
    n_queued++;
    if (len >= ETH_HEADER_BYTES && len <= MAX_FRAME_BYTES && etype == PRP_ETHERTYPE &&
        suffix == PRP_SUFFIX && dev < DEVICES) begin
      if (stamp > gen_last[dev]) gen_last[dev] = stamp;
      hist_q.push_back(f);
      if (hist_q.size() > HISTORY) void'(hist_q.pop_front());
    end
  endtask

  task automatic add_random_frame();
    frame_desc_t h;
    bit [16:0]   len;
    bit [15:0]   etype;
    bit [7:0]    dev;
    bit [15:0]   seq;
    bit [15:0]   suffix;
    bit [63:0]   stamp;
    int unsigned pick;
    etype  = PRP_ETHERTYPE;
    suffix = PRP_SUFFIX;
    pick   = $urandom_range(99);
    if (pick < 20) begin
      dev   = 8'($urandom_range(DEVICES - 1));
      seq   = 16'($urandom);
      len   = 17'($urandom_range(1518, 64));
      stamp = {$urandom, $urandom};
      case ($urandom_range(4))
        0: begin
          etype = 16'($urandom);
          if (etype == PRP_ETHERTYPE) etype[0] = ~etype[0];
          len = 17'($urandom_range(131071));
        end
        1: begin
          len = 17'($urandom_range(ETH_HEADER_BYTES - 1));
          if ($urandom_range(1)) etype = 16'($urandom);
        end
        2: len = 17'($urandom_range(131071, 65536));
        3: begin
          suffix = 16'($urandom);
          if (suffix == PRP_SUFFIX) suffix[0] = ~suffix[0];
        end
        default: dev = 8'($urandom_range(255, DEVICES));
      endcase
    end else begin
      if (pick < 52 && hist_q.size() > 0) begin
        h   = hist_q[$urandom_range(hist_q.size() - 1)];
        dev = h.dev;
        seq = h.seq;
        if ($urandom_range(9) == 0)
          seq = 16'(seq + 16'(SLOTS) * $urandom_range((1 << EPOCH_BITS) - 1, 1));
      end else begin
        dev = ($urandom_range(99) < 70) ? 8'($urandom_range(HOT_DEVICES - 1))
                                        : 8'($urandom_range(DEVICES - 1));
        if ($urandom_range(99) < 80) begin
          seq = next_seq[dev];
          next_seq[dev]++;
        end else begin
          seq = 16'($urandom);
        end
      end
      len = ($urandom_range(99) < 85) ? 17'($urandom_range(1518, 64))
                                      : 17'($urandom_range(MAX_FRAME_BYTES, ETH_HEADER_BYTES));
      pick = $urandom_range(99);
      if (pick < 82) begin
        t_now += $urandom_range(40);
        stamp = t_now;
      end else if (pick < 90) begin
        stamp = gen_last[dev] + 64'(limit_ns) + $urandom_range(1);
      end else if (pick < 96) begin
        stamp = gen_last[dev] - $urandom_range(60);
      end else begin
        t_now += 64'(limit_ns) + $urandom_range(1000);
        stamp = t_now;
      end
    end
    add_frame(len, etype, dev, seq, suffix, stamp);
  endtask

  task automatic drain();
    while (n_accepted != n_queued || verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned count);
    repeat (count) add_random_frame();
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      desc_ch.valid <= 1'b0;
    end else begin
      if (desc_ch.valid && desc_ch.ready) begin
        verdict_q.push_back(judge_frame(on_bus));
        n_accepted++;
      end
      if (!desc_ch.valid || desc_ch.ready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pend_q.pop_front();
          desc_ch.frame_length    <= on_bus.len;
          desc_ch.ether_type      <= on_bus.etype;
          desc_ch.dest_low_byte   <= on_bus.dev;
          desc_ch.seq_number      <= on_bus.seq;
          desc_ch.trailer_suffix  <= on_bus.suffix;
          desc_ch.arrival_time_ns <= on_bus.stamp;
          desc_ch.valid           <= 1'b1;
        end else begin
          desc_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word: verdict %0d cause %0d",
                                  result_ch.verdict, result_ch.drop_cause));
        end else begin
          want = verdict_q.pop_front();
          if (result_ch.verdict !== want.verdict || result_ch.drop_cause !== want.cause)
            flag_mismatch($sformatf("expected verdict %0d cause %0d, got verdict %0d cause %0d",
                                    want.verdict, want.cause,
                                    result_ch.verdict, result_ch.drop_cause));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (desc_ch.valid && desc_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    desc_ch.valid           = 1'b0;
    desc_ch.frame_length    = '0;
    desc_ch.ether_type      = '0;
    desc_ch.dest_low_byte   = '0;
    desc_ch.seq_number      = '0;
    desc_ch.trailer_suffix  = '0;
    desc_ch.arrival_time_ns = '0;
    result_ch.ready         = 1'b0;
    limit_ns                = LIMIT_RESET;
    send_idle_pct           = 0;
    stall_pct               = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    config_write(LIMIT_ADDR, LIMIT_RESET);
    add_frame(17'd0, PRP_ETHERTYPE, 8'd0, 16'h0000, PRP_SUFFIX, 64'd0);
    add_frame(17'd13, 16'h0000, 8'd0, 16'h0000, PRP_SUFFIX, 64'd0);
    add_frame(17'd14, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, '1);
    add_frame(17'h1FFFF, 16'h0800, 8'd0, 16'h0000, 16'h0000, 64'd0);
    add_frame(17'h10000, PRP_ETHERTYPE, 8'd0, 16'h0000, PRP_SUFFIX, 64'd500);
    add_frame(17'h1FFFF, PRP_ETHERTYPE, 8'd0, 16'h0000, PRP_SUFFIX, 64'd500);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd0, 16'h0000, 16'h88FA, 64'd500);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd0, 16'h0000, 16'h0000, 64'd500);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd0, 16'h0000, 16'hFFFF, 64'd500);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd128, 16'h0000, PRP_SUFFIX, 64'd500);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd255, 16'h0000, PRP_SUFFIX, 64'd500);
    add_frame(17'd14, PRP_ETHERTYPE, 8'd0, 16'h0000, PRP_SUFFIX, 64'd1000);
    add_frame(17'd19, PRP_ETHERTYPE, 8'd0, 16'h0000, PRP_SUFFIX, 64'd1000);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd0, 16'h1000, PRP_SUFFIX, 64'd1010);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd0, 16'h0000, PRP_SUFFIX, 64'd1020);
    add_frame(MAX_FRAME_BYTES, PRP_ETHERTYPE, 8'd127, 16'hFFFF, PRP_SUFFIX, 64'd1000);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd127, 16'hFFFF, PRP_SUFFIX, 64'd900);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd127, 16'hFFFF, PRP_SUFFIX, 64'd1000);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd127, 16'hFFFF, PRP_SUFFIX, 64'd1000 + 64'(limit_ns));
    add_frame(17'd64, PRP_ETHERTYPE, 8'd127, 16'hFFFF, PRP_SUFFIX,
              64'd1001 + 64'(limit_ns) * 2);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd126, 16'h0FFF, PRP_SUFFIX, '1);
    add_frame(17'd64, PRP_ETHERTYPE, 8'd126, 16'h0FFF, PRP_SUFFIX, '1);
    t_now = 64'd1000 + 64'(limit_ns) * 3;
    run_phase(PHASE_ITEMS);

    send_idle_pct = 64;
    config_write(SPARE_ADDR, 32'hDEAD_BEEF);
    config_write(LIMIT_ADDR, 32'd5000);
    run_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    stall_pct     = 64;
    config_write(LIMIT_ADDR, 32'd0);
    run_phase(PHASE_ITEMS);

    send_idle_pct = 11;
    stall_pct     = 11;
    config_write(LIMIT_ADDR, 32'hFFFF_FFFF);
    run_phase(PHASE_ITEMS);

    repeat (300) @(posedge clk);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/prp_dd_pkg.sv
rtl/core/prp_dd_desc_if.sv
rtl/core/prp_dd_result_if.sv
rtl/core/prp_dd_ram.sv
rtl/core/prp_dd_cfg.sv
rtl/core/prp_duplicate_discard_core.sv
tb/sv/tb_prp_duplicate_discard_core.sv
